@@ rtl/sus_pkg.sv @@
// Package for the sorted unique set: sizes, action and status codes,
// controller states and the payload structs of both channels.
// No dependencies.
package sus_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_READ_RD,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
    } sus_in_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } sus_out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } sus_ram_req_t;

endpackage

@@ rtl/sus_ram.sv @@
// Single-port entry store of the sorted unique set with a registered read.
// Depends on sus_pkg.
module sus_ram (
    input  logic                       aclk,
    input  sus_pkg::sus_ram_req_t      req,
    output logic [sus_pkg::DATA_W-1:0] rdata
);
    import sus_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

@@ rtl/sorted_unique_set.sv @@
// Top level of the sorted unique set: controller, count and result register.
// Depends on sus_pkg and sus_ram.
//
//   Port group        Direction  Carries
//   s_valid/s_ready   in         sus_in_t: action, value, index
//   m_valid/m_ready   out        sus_out_t: status, read_value, count
//
// One item at a time. An in-range read goes through S_READ_RD and S_READ_WAIT
// to S_FINISH; an out-of-range read and action code 3 go straight to S_FINISH.
// Insert and delete run a binary search (S_SRCH, then S_SRCH_CMP, per step) over the
// single memory port, then move each shifted entry with a read and a write.
// Reset clears the count, the controller state and m_valid; the entries need no clearing.
// A result waiting on m_ready stalls only the final step of the next item.
module sorted_unique_set (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sus_pkg::sus_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sus_pkg::sus_out_t m_data
);
    import sus_pkg::*;

    state_t                   state_reg, state_next;
    action_t                  act_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         lo_reg, hi_reg, mid_reg, ptr_reg;
    logic                     found_reg;
    status_t                  status_reg;
    logic [DATA_W-1:0]        rd_reg;
    logic                     m_valid_reg;
    sus_out_t                 m_data_reg;

    sus_ram_req_t             ram_req;
    logic [DATA_W-1:0]        ram_rdata;
    logic [CNT_W:0]           mid_sum;
    logic [CNT_W-1:0]         mid;
    logic                     out_free;
    logic                     read_ok;

    sus_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];
    assign out_free = !m_valid_reg || m_ready;
    assign read_ok  = (32'(s_data.index) < 32'(count_reg)) && (32'(s_data.index) < CAPACITY);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (action_t'(s_data.action))
                        ACT_INSERT, ACT_DELETE: state_next = S_SRCH;
                        ACT_READ:   state_next = read_ok ? S_READ_RD : S_FINISH;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_SRCH:      state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_DECIDE;
            S_SRCH_CMP:  state_next = S_SRCH;
            S_DECIDE: begin
                if (act_reg == ACT_INSERT) begin
                    if (found_reg || count_reg == CNT_W'(CAPACITY)) begin
                        state_next = S_FINISH;
                    end else if (count_reg > lo_reg) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        state_next = S_PUT;
                    end
                end else begin
                    if (!found_reg) begin
                        state_next = S_FINISH;
                    end else if ({1'b0, lo_reg} + 1'b1 < {1'b0, count_reg}) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (act_reg == ACT_INSERT) begin
                    state_next = (ptr_reg - 1'b1 > lo_reg) ? S_SHIFT_RD : S_PUT;
                end else begin
                    state_next = ({1'b0, ptr_reg} + 2'd2 < {1'b0, count_reg}) ?
                                 S_SHIFT_RD : S_FINISH;
                end
            end
            S_PUT:       state_next = S_FINISH;
            S_READ_RD:   state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_FINISH;
            S_FINISH:    state_next = out_free ? S_IDLE : S_FINISH;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        ram_req.we    = 1'b0;
        ram_req.addr  = mid[ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        unique case (state_reg)
            S_SHIFT_RD: begin
                if (act_reg == ACT_INSERT) begin
                    ram_req.addr = ADDR_W'(ptr_reg - 1'b1);
                end else begin
                    ram_req.addr = ADDR_W'(ptr_reg + 1'b1);
                end
            end
            S_SHIFT_WR: begin
                ram_req.we   = 1'b1;
                ram_req.addr = ptr_reg[ADDR_W-1:0];
            end
            S_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = lo_reg[ADDR_W-1:0];
                ram_req.wdata = val_reg;
            end
            S_READ_RD:   ram_req.addr = ADDR_W'(idx_reg);
            default:     ram_req.addr = mid[ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_PUT) begin
                count_reg <= count_reg + 1'b1;
            end
            if (act_reg == ACT_DELETE && state_next == S_FINISH && found_reg &&
                (state_reg == S_DECIDE || state_reg == S_SHIFT_WR)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                act_reg    <= action_t'(s_data.action);
                val_reg    <= s_data.value;
                idx_reg    <= s_data.index;
                lo_reg     <= '0;
                hi_reg     <= count_reg;
                found_reg  <= 1'b0;
                rd_reg     <= '0;
                status_reg <= (action_t'(s_data.action) == ACT_READ && !read_ok) ?
                              ST_RANGE : ST_DONE;
            end
            S_SRCH:      mid_reg <= mid;
            S_SRCH_CMP: begin
                if ($signed(ram_rdata) < val_reg) begin
                    lo_reg <= mid_reg + 1'b1;
                end else begin
                    hi_reg <= mid_reg;
                end
                if (ram_rdata == val_reg) begin
                    found_reg <= 1'b1;
                end
            end
            S_DECIDE: begin
                if (act_reg == ACT_INSERT) begin
                    ptr_reg <= count_reg;
                    if (found_reg) begin
                        status_reg <= ST_DUP;
                    end else if (count_reg == CNT_W'(CAPACITY)) begin
                        status_reg <= ST_FULL;
                    end
                end else begin
                    ptr_reg <= lo_reg;
                    if (!found_reg) begin
                        status_reg <= ST_NOTFOUND;
                    end
                end
            end
            S_SHIFT_WR: begin
                if (act_reg == ACT_INSERT) begin
                    ptr_reg <= ptr_reg - 1'b1;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            S_READ_WAIT: rd_reg <= ram_rdata;
            S_FINISH: begin
                if (out_free) begin
                    m_data_reg.status     <= status_reg;
                    m_data_reg.read_value <= rd_reg;
                    m_data_reg.count      <= COUNT_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for sorted_unique_set: a directed table, then random
// phases that fill, churn and drain the set, checked against a queue-based predictor.
// Depends on sus_pkg and the sorted_unique_set RTL.
`timescale 1ns / 1ps

module tb_top;
    import sus_pkg::*;

    localparam int RAND_ITEMS  = 1200;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } phase_t;

    typedef struct {
        action_t                  act;
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
        bit                       fixed;
        status_t                  st;
        logic signed [DATA_W-1:0] rv;
        logic [COUNT_W-1:0]       cnt;
    } probe_t;

    logic     aclk       = 1'b0;
    logic     aresetn    = 1'b0;
    logic     s_valid    = 1'b0;
    logic     s_ready;
    sus_in_t  s_data     = '0;
    logic     m_valid;
    logic     m_ready    = 1'b0;
    sus_out_t m_data;

    logic     pend_fixed = 1'b0;
    sus_out_t pend_out   = '0;
    bit       quiet      = 1'b0;
    int       fail_count = 0;
    int       cycles     = 0;

    int       mirror_vals[$];
    sus_out_t owed_results[$];

    probe_t probes [0:23] = '{
        '{ACT_READ,   32'sd0,        6'd0,  1'b1, ST_RANGE,    32'sd0,        7'd0},
        '{ACT_DELETE, 32'sd5,        6'd0,  1'b1, ST_NOTFOUND, 32'sd0,        7'd0},
        '{ACT_NOP,    32'hFFFFFFFF,  6'd63, 1'b1, ST_DONE,     32'sd0,        7'd0},
        '{ACT_INSERT, 32'sd0,        6'd0,  1'b1, ST_DONE,     32'sd0,        7'd1},
        '{ACT_INSERT, 32'h7FFFFFFF,  6'd0,  1'b1, ST_DONE,     32'sd0,        7'd2},
        '{ACT_INSERT, 32'h80000000,  6'd0,  1'b1, ST_DONE,     32'sd0,        7'd3},
        '{ACT_INSERT, 32'hFFFFFFFF,  6'd0,  1'b1, ST_DONE,     32'sd0,        7'd4},
        '{ACT_INSERT, 32'sd0,        6'd0,  1'b1, ST_DUP,      32'sd0,        7'd4},
        '{ACT_READ,   32'sd0,        6'd0,  1'b1, ST_DONE,     32'h80000000,  7'd4},
        '{ACT_READ,   32'sd0,        6'd1,  1'b1, ST_DONE,     32'hFFFFFFFF,  7'd4},
        '{ACT_READ,   32'sd0,        6'd2,  1'b1, ST_DONE,     32'sd0,        7'd4},
        '{ACT_READ,   32'sd0,        6'd3,  1'b1, ST_DONE,     32'h7FFFFFFF,  7'd4},
        '{ACT_READ,   32'sd0,        6'd4,  1'b1, ST_RANGE,    32'sd0,        7'd4},
        '{ACT_READ,   32'hFFFFFFFF,  6'd63, 1'b1, ST_RANGE,    32'sd0,        7'd4},
        '{ACT_INSERT, 32'sd42,       6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_INSERT, -32'sd42,      6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_DELETE, 32'h80000000,  6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_DELETE, 32'h7FFFFFFF,  6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_DELETE, 32'sd7,        6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_NOP,    32'sd0,        6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_INSERT, 32'sd1,        6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_DELETE, 32'sd0,        6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_READ,   32'sd0,        6'd1,  1'b0, ST_DONE,     32'sd0,        7'd0},
        '{ACT_INSERT, 32'h80000001,  6'd0,  1'b0, ST_DONE,     32'sd0,        7'd0}
    };

    sorted_unique_set u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic sus_out_t apply_action(sus_in_t it);
        sus_out_t res;
        int       slot;
        int       v;
        res  = '0;
        v    = it.value;
        slot = 0;
        case (action_t'(it.action))
            ACT_INSERT: begin
                while (slot < mirror_vals.size() && mirror_vals[slot] < v) slot++;
                if (slot < mirror_vals.size() && mirror_vals[slot] == v) begin
                    res.status = ST_DUP;
                end else if (mirror_vals.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_vals.insert(slot, v);
                end
            end
            ACT_DELETE: begin
                while (slot < mirror_vals.size() && mirror_vals[slot] != v) slot++;
                if (slot >= mirror_vals.size()) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    mirror_vals.delete(slot);
                end
            end
            ACT_READ: begin
                if (it.index < mirror_vals.size()) begin
                    res.read_value = mirror_vals[it.index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(mirror_vals.size());
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(int hit_pct);
        int n;
        int roll;
        n    = mirror_vals.size();
        roll = $urandom_range(0, 99);
        if (n > 0 && roll < hit_pct) return mirror_vals[$urandom_range(0, n - 1)];
        roll = $urandom_range(0, 9);
        if (roll < 4) return int'($urandom_range(0, 80)) - 40;
        if (roll < 5) begin
            case ($urandom_range(0, 3))
                0: return 32'h80000000;
                1: return 32'h7FFFFFFF;
                2: return 32'h80000001;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic sus_in_t random_item(phase_t ph);
        sus_in_t it;
        action_t act;
        int      roll;
        int      n;
        n    = mirror_vals.size();
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  act = roll < 75 ? ACT_INSERT : roll < 80 ? ACT_DELETE :
                            roll < 95 ? ACT_READ : ACT_NOP;
            PH_DRAIN: act = roll < 70 ? ACT_DELETE : roll < 80 ? ACT_INSERT :
                            roll < 95 ? ACT_READ : ACT_NOP;
            default:  act = roll < 40 ? ACT_INSERT : roll < 75 ? ACT_DELETE :
                            roll < 95 ? ACT_READ : ACT_NOP;
        endcase
        it.action = act;
        if (act == ACT_DELETE) begin
            it.value = pick_value(ph == PH_DRAIN ? 85 : 60);
        end else begin
            it.value = pick_value(ph == PH_FILL ? 5 : 25);
        end
        if (act == ACT_READ && n > 0 && $urandom_range(0, 9) < 7) begin
            it.index = INDEX_W'($urandom_range(0, n - 1));
        end else begin
            it.index = INDEX_W'($urandom_range(0, 63));
        end
        return it;
    endfunction

    task automatic send_item(input sus_in_t it, input logic fixed, input sus_out_t fixed_out);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            repeat (n) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_data     <= it;
        pend_fixed <= fixed;
        pend_out   <= fixed_out;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    initial begin : result_ready
        int n;
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 14);
                repeat (n) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            n = $urandom_range(1, 40);
            repeat (n) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : scoreboard
        sus_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error({"result transfer with nothing expected: ",
                            "status %0d read_value %0d count %0d"},
                           m_data.status, m_data.read_value, m_data.count);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status expected %0d, got %0d", want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.read_value !== want.read_value) begin
                        $error("read_value expected %0d, got %0d",
                               want.read_value, m_data.read_value);
                        fail_count++;
                    end
                    if (m_data.count !== want.count) begin
                        $error("count expected %0d, got %0d", want.count, m_data.count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_action(s_data);
                if (pend_fixed) want = pend_out;
                owed_results.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sorted_unique_set verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        sus_in_t  it;
        sus_out_t fixed_out;
        phase_t   ph;
        int       seg_left;
        int       seg_no;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) begin
            it.action            = probes[i].act;
            it.value             = probes[i].value;
            it.index             = probes[i].index;
            fixed_out.status     = probes[i].st;
            fixed_out.read_value = probes[i].rv;
            fixed_out.count      = probes[i].cnt;
            send_item(it, probes[i].fixed, fixed_out);
        end

        // Phases cycle fill, mix, drain, mix so the set is driven to full and back to empty.
        seg_no   = 0;
        seg_left = 0;
        ph       = PH_FILL;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (seg_left == 0) begin
                case (seg_no % 4)
                    0: ph = PH_FILL;
                    2: ph = PH_DRAIN;
                    default: ph = PH_MIX;
                endcase
                seg_left = (ph == PH_MIX) ? $urandom_range(60, 100) : $urandom_range(110, 150);
                seg_no++;
            end
            seg_left--;
            if (k == RAND_ITEMS / 2) wait_drained();
            if (k == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_item(random_item(ph), 1'b0, '0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("sorted_unique_set verification clean");
        end else begin
            $display("sorted_unique_set verification failed");
        end
        $finish;
    end

endmodule
